// ===== hw/rtl/cll_pkg.sv =====
// shared types and constants for the cursor linked list engine
package cll_pkg;

   typedef enum logic [2:0] {
      OP_INSERT   = 3'd0,
      OP_DELETE   = 3'd1,
      OP_LOCATE   = 3'd2,
      OP_RETRIEVE = 3'd3,
      OP_NEXT     = 3'd4,
      OP_PREVIOUS = 3'd5,
      OP_CLEAR    = 3'd6,
      OP_ALLOCATE = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDEF = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_DISPATCH,
      S_WALK_RD,
      S_WALK_EV,
      S_FREE_RD,
      S_FREE_EV,
      S_EXEC,
      S_EXEC2,
      S_CLR_RD,
      S_CLR_EV,
      S_DONE
   } state_type;

   // datapath commands from the controller
   typedef struct packed {
      logic load;       // capture request
      logic init_step;  // write one link of the reset chain
      logic walk_start; // start walking the list from the head
      logic free_start; // start walking the free chain
      logic rd_cur;     // issue read of current walk slot
      logic walk_adv;   // advance walk to the link just read
      logic free_adv;   // advance free walk
      logic exec;       // first write phase of the operation
      logic exec2;      // second write phase
      logic clr_start;  // start clear pass
      logic clr_step;   // release one slot during clear
      logic finish;     // load result register
   } cmd_type;

   // datapath status to the controller
   typedef struct packed {
      logic init_done;
      logic head_zero;
      logic free_zero;
      logic walk_end;   // current walk slot is null or step limit reached
      logic walk_hit;   // current walk slot matches the search
      logic free_hit;
      logic walk_is_locate;
      logic need_free;  // append path must check the free chain
      logic two_phase;  // operation needs a second write
      logic out_busy;
   } stat_type;

endpackage

// ===== hw/rtl/cll_ram.sv =====
// generic single-write two-read ram with registered read data
module cll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   output logic [WIDTH-1:0]         rdata_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end
endmodule

// ===== hw/rtl/cll_ctrl.sv =====
// controller state machine for the cursor linked list engine
module cll_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  cll_pkg::op_type   op,
   input  cll_pkg::stat_type st,
   output cll_pkg::cmd_type  cmd
);
   cll_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cll_pkg::S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         cll_pkg::S_INIT: begin
            cmd.init_step = 1'b1;
            if (st.init_done) state_in = cll_pkg::S_IDLE;
         end
         cll_pkg::S_IDLE: begin
            req_tready = !st.out_busy;
            if (req_tvalid && !st.out_busy) begin
               cmd.load = 1'b1;
               state_in = cll_pkg::S_DISPATCH;
            end
         end
         cll_pkg::S_DISPATCH: begin
            case (op)
               cll_pkg::OP_ALLOCATE: state_in = cll_pkg::S_EXEC;
               cll_pkg::OP_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  state_in = cll_pkg::S_CLR_RD;
               end
               default: begin
                  cmd.walk_start = 1'b1;
                  state_in = cll_pkg::S_WALK_RD;
               end
            endcase
         end
         cll_pkg::S_WALK_RD: begin
            if (st.walk_end || st.walk_hit) begin
               if (st.need_free && !st.walk_hit) begin
                  cmd.free_start = 1'b1;
                  state_in = cll_pkg::S_FREE_RD;
               end else begin
                  state_in = cll_pkg::S_EXEC;
               end
            end else begin
               cmd.rd_cur = 1'b1;
               state_in = cll_pkg::S_WALK_EV;
            end
         end
         cll_pkg::S_WALK_EV: begin
            if (st.walk_is_locate && st.walk_hit) begin
               state_in = cll_pkg::S_EXEC;
            end else begin
               cmd.walk_adv = 1'b1;
               state_in = cll_pkg::S_WALK_RD;
            end
         end
         cll_pkg::S_FREE_RD: begin
            if (st.walk_end || st.free_hit) begin
               state_in = cll_pkg::S_EXEC;
            end else begin
               cmd.rd_cur = 1'b1;
               state_in = cll_pkg::S_FREE_EV;
            end
         end
         cll_pkg::S_FREE_EV: begin
            cmd.free_adv = 1'b1;
            state_in = cll_pkg::S_FREE_RD;
         end
         cll_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = st.two_phase ? cll_pkg::S_EXEC2 : cll_pkg::S_DONE;
         end
         cll_pkg::S_EXEC2: begin
            cmd.exec2 = 1'b1;
            state_in = cll_pkg::S_DONE;
         end
         cll_pkg::S_CLR_RD: begin
            if (st.walk_end) begin
               state_in = cll_pkg::S_DONE;
            end else begin
               cmd.rd_cur = 1'b1;
               state_in = cll_pkg::S_CLR_EV;
            end
         end
         cll_pkg::S_CLR_EV: begin
            cmd.clr_step = 1'b1;
            state_in = cll_pkg::S_CLR_RD;
         end
         cll_pkg::S_DONE: begin
            cmd.finish = 1'b1;
            state_in = cll_pkg::S_IDLE;
         end
         default: state_in = cll_pkg::S_IDLE;
      endcase
   end
endmodule

// ===== hw/rtl/cll_dp.sv =====
// datapath: slot stores, list pointers, walk registers and result register
module cll_dp #(
   parameter int SLOTS      = 31,
   parameter int VALUE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  cll_pkg::cmd_type  cmd,
   output cll_pkg::stat_type st,
   output cll_pkg::op_type   op,
   input  logic [2:0]        req_op,
   input  logic [4:0]        req_slot,
   input  logic [31:0]       req_value,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [1:0]        rsp_status,
   output logic [4:0]        rsp_slot,
   output logic [31:0]       rsp_value,
   output logic [4:0]        rsp_head
);
   localparam int AW    = $clog2(SLOTS + 1);
   localparam int DEPTH = 1 << AW;
   localparam int VW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam logic [AW-1:0] LAST = AW'(SLOTS);

   cll_pkg::op_type  op_ff;
   logic [4:0]       slot_ff;
   logic [VW-1:0]    val_ff;
   logic [AW-1:0]    head_ff, head_in, fhead_ff, fhead_in;
   logic [AW-1:0]    cur_ff, cur_in, prev_ff, prev_in, last_ff, last_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             hit_ff, hit_in, fhit_ff, fhit_in;
   logic [AW-1:0]    init_ff;
   logic             idone_ff;
   logic             rd_pend_ff;
   logic             ovalid_ff;
   logic [1:0]       ost_ff;
   logic [4:0]       oslot_ff, oslot_in;
   logic [31:0]      oval_ff;
   logic [1:0]       res_st_ff, res_st_in;
   logic [AW-1:0]    take_ff, take_in;
   // link and value ram ports
   logic             lwe, vwe;
   logic [AW-1:0]    lwa, vwa, lra, lrb;
   logic [AW-1:0]    lwd, lrda, lrdb;
   logic [VW-1:0]    vwd, vrda, vrdb;
   logic [AW-1:0]    vra;
   logic             p_ok;
   logic [AW-1:0]    p;
   logic             vmatch;

   cll_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_links (
      .clock(clock), .we(lwe), .waddr(lwa), .wdata(lwd),
      .raddr_a(lra), .rdata_a(lrda), .raddr_b(lrb), .rdata_b(lrdb)
   );
   cll_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_values (
      .clock(clock), .we(vwe), .waddr(vwa), .wdata(vwd),
      .raddr_a(vra), .rdata_a(vrda), .raddr_b(p), .rdata_b(vrdb)
   );

   assign op     = op_ff;
   assign p_ok   = (slot_ff != 5'd0) && ({3'd0, slot_ff} <= 8'(SLOTS));
   assign p      = AW'(slot_ff);
   assign vmatch = (vrda == val_ff);

   // status to the controller
   always_comb begin
      st = '0;
      st.init_done      = idone_ff;
      st.head_zero      = (head_ff == '0);
      st.free_zero      = (fhead_ff == '0);
      st.walk_end       = (cur_ff == '0) || (cnt_ff >= (AW+1)'(SLOTS));
      st.walk_hit       = hit_ff;
      st.free_hit       = fhit_ff;
      st.walk_is_locate = (op_ff == cll_pkg::OP_LOCATE);
      st.need_free      = (op_ff == cll_pkg::OP_INSERT) && (head_ff != '0) && p_ok;
      st.two_phase      = 1'b0;
      st.out_busy       = ovalid_ff;
      // insert at a listed slot writes the slot itself in phase two
      if (op_ff == cll_pkg::OP_INSERT && head_ff != '0 && hit_ff && fhead_ff != '0)
         st.two_phase = 1'b1;
      // append links the old tail in phase two
      if (op_ff == cll_pkg::OP_INSERT && head_ff != '0 && !hit_ff && p_ok && !fhit_ff)
         st.two_phase = 1'b1;
      // delete releases the slot in phase two
      if (op_ff == cll_pkg::OP_DELETE && hit_ff)
         st.two_phase = 1'b1;
      // locate compares the value read in the evaluate cycle
      if (op_ff == cll_pkg::OP_LOCATE)
         st.walk_hit = rd_pend_ff && vmatch;
   end

   // ram addressing and writes
   always_comb begin
      lwe = 1'b0; lwa = '0; lwd = '0;
      vwe = 1'b0; vwa = '0; vwd = val_ff;
      lra = cmd.rd_cur ? cur_ff : fhead_ff; lrb = p; vra = cur_ff;
      if (!idone_ff) begin
         lwe = 1'b1; lwa = init_ff;
         lwd = (init_ff == '0 || init_ff == LAST) ? '0 : init_ff + AW'(1);
      end
      if (cmd.clr_step) begin
         lwe = 1'b1; lwa = cur_ff; lwd = fhead_ff;
      end
      if (cmd.exec) begin
         case (op_ff)
            cll_pkg::OP_INSERT: begin
               if (head_ff == '0) begin
                  if (fhead_ff != '0) begin
                     lwe = 1'b1; lwa = fhead_ff; lwd = '0;
                     vwe = 1'b1; vwa = fhead_ff;
                  end
               end else if (hit_ff) begin
                  // move old link and value to the taken slot, new value in phase two
                  if (fhead_ff != '0) begin
                     lwe = 1'b1; lwa = fhead_ff; lwd = lrdb;
                     vwe = 1'b1; vwa = fhead_ff; vwd = vrdb;
                  end
               end else if (p_ok && !fhit_ff) begin
                  lwe = 1'b1; lwa = p; lwd = '0;
                  vwe = 1'b1; vwa = p;
               end
            end
            cll_pkg::OP_DELETE: begin
               if (hit_ff) begin
                  lwe = 1'b1;
                  lwa = (p == head_ff) ? p : prev_ff;
                  lwd = (p == head_ff) ? fhead_ff : lrdb;
               end
            end
            default: ;
         endcase
      end
      if (cmd.exec2) begin
         case (op_ff)
            cll_pkg::OP_INSERT: begin
               if (hit_ff) begin
                  lwe = 1'b1; lwa = p; lwd = take_ff;
                  vwe = 1'b1; vwa = p;
               end else begin
                  lwe = 1'b1; lwa = last_ff; lwd = p;
               end
            end
            default: ;
         endcase
      end
      if (cmd.exec2 && op_ff == cll_pkg::OP_DELETE) begin
         lwe = 1'b1; lwa = p; lwd = fhead_ff;
      end
   end

   // walk and pointer updates
   always_comb begin
      head_in = head_ff; fhead_in = fhead_ff;
      cur_in = cur_ff; prev_in = prev_ff; last_in = last_ff; cnt_in = cnt_ff;
      hit_in = hit_ff; fhit_in = fhit_ff; take_in = take_ff;
      res_st_in = res_st_ff; oslot_in = oslot_ff;
      if (cmd.walk_start || cmd.clr_start) begin
         cur_in = head_ff; prev_in = head_ff; last_in = '0; cnt_in = '0;
         hit_in = 1'b0; fhit_in = 1'b0;
      end
      if (cmd.clr_start) begin
         res_st_in = cll_pkg::ST_OK; oslot_in = '0;
      end
      if (cmd.walk_start && op_ff != cll_pkg::OP_LOCATE)
         hit_in = p_ok && (head_ff == p) && (head_ff != '0);
      if (cmd.free_start) begin
         cur_in = fhead_ff; cnt_in = '0;
         fhit_in = (fhead_ff == p);
      end
      if (cmd.walk_adv) begin
         last_in = cur_ff;
         prev_in = cur_ff;
         cur_in  = lrda;
         cnt_in  = cnt_ff + 1'b1;
         if (op_ff != cll_pkg::OP_LOCATE)
            hit_in = p_ok && (lrda == p) && (lrda != '0) && (cnt_ff + 1'b1 < (AW+1)'(SLOTS));
      end
      if (cmd.rd_cur && op_ff == cll_pkg::OP_LOCATE) begin
         hit_in = 1'b0;
      end
      if (op_ff == cll_pkg::OP_LOCATE && rd_pend_ff && vmatch) begin
         hit_in = 1'b1;
      end
      if (cmd.free_adv) begin
         cur_in = lrda; cnt_in = cnt_ff + 1'b1;
         fhit_in = (lrda == p) && (cnt_ff + 1'b1 < (AW+1)'(SLOTS));
      end
      if (cmd.clr_step) begin
         fhead_in = cur_ff; cur_in = lrda; cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.exec) begin
         res_st_in = cll_pkg::ST_OK; oslot_in = '0; take_in = fhead_ff;
         case (op_ff)
            cll_pkg::OP_INSERT: begin
               if (head_ff == '0) begin
                  if (fhead_ff == '0) res_st_in = cll_pkg::ST_FULL;
                  else begin
                     head_in = fhead_ff; fhead_in = lrda; oslot_in = 5'(fhead_ff);
                  end
               end else if (hit_ff) begin
                  if (fhead_ff == '0) res_st_in = cll_pkg::ST_FULL;
                  else begin
                     fhead_in = lrda; oslot_in = slot_ff;
                  end
               end else if (!p_ok || fhit_ff) begin
                  res_st_in = cll_pkg::ST_UNDEF;
               end else begin
                  oslot_in = slot_ff;
               end
            end
            cll_pkg::OP_DELETE: begin
               if (!hit_ff) begin
                  res_st_in = cll_pkg::ST_UNDEF; oslot_in = slot_ff;
               end else begin
                  oslot_in = 5'(lrdb);
                  if (p == head_ff) head_in = lrdb;
               end
            end
            cll_pkg::OP_LOCATE: oslot_in = hit_ff ? 5'(cur_ff) : 5'd0;
            cll_pkg::OP_RETRIEVE: begin
               if (!hit_ff) res_st_in = cll_pkg::ST_UNDEF;
               else oslot_in = slot_ff;
            end
            cll_pkg::OP_NEXT: begin
               if (!hit_ff) res_st_in = cll_pkg::ST_UNDEF;
               else oslot_in = 5'(lrdb);
            end
            cll_pkg::OP_PREVIOUS: begin
               if (!hit_ff || p == head_ff) res_st_in = cll_pkg::ST_UNDEF;
               else oslot_in = 5'(prev_ff);
            end
            cll_pkg::OP_ALLOCATE: begin
               if (fhead_ff == '0) res_st_in = cll_pkg::ST_FULL;
               else begin
                  oslot_in = 5'(fhead_ff); fhead_in = lrda;
               end
            end
            default: ;
         endcase
      end
      if (cmd.exec2 && op_ff == cll_pkg::OP_DELETE) fhead_in = p;
      if (cmd.finish && op_ff == cll_pkg::OP_CLEAR) begin
         head_in = '0;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         fhead_ff   <= AW'(1);
         init_ff    <= '0;
         idone_ff   <= 1'b0;
         rd_pend_ff <= 1'b0;
         ovalid_ff  <= 1'b0;
      end else begin
         head_ff    <= head_in;
         fhead_ff   <= fhead_in;
         rd_pend_ff <= cmd.rd_cur;
         if (!idone_ff) begin
            init_ff <= init_ff + AW'(1);
            if (init_ff == AW'(DEPTH - 1)) idone_ff <= 1'b1;
         end
         if (cmd.finish) ovalid_ff <= 1'b1;
         else if (rsp_tready) ovalid_ff <= 1'b0;
      end
   end

   // request capture, walk state and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= cll_pkg::op_type'(req_op);
         slot_ff <= req_slot;
         val_ff  <= req_value[VW-1:0];
      end
      cur_ff <= cur_in; prev_ff <= prev_in; last_ff <= last_in; cnt_ff <= cnt_in;
      hit_ff <= hit_in; fhit_ff <= fhit_in; take_ff <= take_in;
      res_st_ff <= res_st_in; oslot_ff <= oslot_in;
      if (cmd.finish) begin
         ost_ff   <= res_st_ff;
         oval_ff  <= (op_ff == cll_pkg::OP_RETRIEVE && res_st_ff == cll_pkg::ST_OK)
                     ? 32'(vrdb) : 32'd0;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_status = ost_ff;
   assign rsp_slot   = oslot_ff;
   assign rsp_value  = oval_ff;
   assign rsp_head   = 5'(head_ff);
endmodule

// ===== hw/rtl/cursor_linked_list_engine.sv =====
// Cursor linked list engine top level.
// A singly linked list and a free chain share one slot store held in two small
// RAMs (values and links). One request is taken at a time and yields one response.
// Requests that search the list (insert, delete, retrieve, next, previous) walk it
// one link read at a time, each read followed by an evaluate state, over at most
// SLOTS links. An insert into a non-empty list or a delete that changes the list
// adds a second write, and an append also walks the free chain to check its slot.
// A locate stops at the first slot whose value matches. Allocate takes the free
// head without a walk, and clear walks the list to release its slots. The next
// request is taken the cycle after the response is accepted. After reset a pass
// over the link RAM builds the free chain before the first request is accepted.
module cursor_linked_list_engine #(
   parameter int SLOTS      = 31,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // operation[2:0], slot[7:3], value[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // status[1:0], slot_out[6:2], value_out[38:7], head_out[43:39]
);
   cll_pkg::cmd_type  cmd;
   cll_pkg::stat_type st;
   cll_pkg::op_type   op;
   logic [1:0]  status;
   logic [4:0]  slot_out, head_out;
   logic [31:0] value_out;

   cll_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .op(op), .st(st), .cmd(cmd)
   );

   cll_dp #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .st(st), .op(op),
      .req_op(req_tdata[2:0]), .req_slot(req_tdata[7:3]), .req_value(req_tdata[39:8]),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_status(status), .rsp_slot(slot_out), .rsp_value(value_out), .rsp_head(head_out)
   );

   assign rsp_tdata = {4'd0, head_out, value_out, slot_out, status};
endmodule

// ===== hw/rtl/cll_checker.sv =====
// port-level checker for the cursor linked list engine, with its bind
module cll_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   // a response holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // one request at a time: no acceptance right after another
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // status code is never the unused value
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("bad status code");

   // value is zero unless status ok
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != 2'd0 |-> rsp_tdata[38:7] == 32'd0)
      else $error("value on failed request");
endmodule

bind cursor_linked_list_engine cll_checker u_cll_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// ===== bench/tb_cursor_linked_list_engine.sv =====
// self-checking bench for the cursor linked list engine: random streams against a built-in list model
module tb_cursor_linked_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 31;
   localparam int WATCH_LIMIT = 20000;

   typedef struct packed {
      logic [31:0]      value;
      logic [4:0]       slot;
      cll_pkg::op_type  op;
   } request_type;

   typedef struct packed {
      logic [4:0]          head_out;
      logic [31:0]         value_out;
      logic [4:0]          slot_out;
      cll_pkg::status_type status;
   } response_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;

   cursor_linked_list_engine u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   request_type  pending_requests[$];
   response_type expected_responses[$];
   int           error_count = 0;
   int           send_idle_pct = 21;
   int           recv_idle_pct = 84;
   bit           stimulus_done = 0;
   int           quiet_cycles = 0;

   // model state of the slot store
   logic [31:0] mdl_values[SLOTS+1];
   logic [4:0]  mdl_links[SLOTS+1];
   logic [4:0]  mdl_list_head;
   logic [4:0]  mdl_free_head;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [4:0] link_of(logic [4:0] s);
      return (s <= SLOTS) ? mdl_links[s] : 5'd0;
   endfunction

   function automatic bit is_listed(logic [4:0] s, output logic [4:0] pred);
      logic [4:0] cur;
      logic [4:0] prv;
      cur = mdl_list_head;
      prv = mdl_list_head;
      pred = 0;
      if (s == 0 || s > SLOTS || mdl_list_head == 0) return 0;
      for (int n = 0; n < SLOTS && cur != 0; n++) begin
         if (cur == s) begin
            pred = prv;
            return 1;
         end
         prv = cur;
         cur = link_of(cur);
      end
      return 0;
   endfunction

   function automatic bit is_free(logic [4:0] s);
      logic [4:0] cur;
      cur = mdl_free_head;
      for (int n = 0; n < SLOTS && cur != 0; n++) begin
         if (cur == s) return 1;
         cur = link_of(cur);
      end
      return 0;
   endfunction

   function automatic void release_slot(logic [4:0] s);
      if (s == 0 || s > SLOTS) return;
      mdl_links[s] = mdl_free_head;
      mdl_free_head = s;
   endfunction

   function automatic logic [4:0] take_slot();
      logic [4:0] s;
      s = mdl_free_head;
      mdl_free_head = link_of(s);
      return s;
   endfunction

   function automatic void list_reset();
      for (int i = 0; i <= SLOTS; i++) begin
         mdl_values[i] = 0;
         mdl_links[i] = (i == 0 || i == SLOTS) ? 5'd0 : 5'(i + 1);
      end
      mdl_list_head = 0;
      mdl_free_head = 1;
   endfunction

   // apply one request to the model and return the response it gives
   function automatic response_type list_apply(request_type rq);
      response_type rs;
      logic [4:0]   pred;
      logic [4:0]   cur;
      logic [4:0]   nx;
      logic [4:0]   p;
      rs = '0;
      rs.status = cll_pkg::ST_OK;
      p = rq.slot;
      case (rq.op)
         cll_pkg::OP_INSERT: begin
            if (mdl_list_head == 0) begin
               if (mdl_free_head == 0) rs.status = cll_pkg::ST_FULL;
               else begin
                  cur = take_slot();
                  mdl_values[cur] = rq.value;
                  mdl_links[cur] = 0;
                  mdl_list_head = cur;
                  rs.slot_out = cur;
               end
            end else if (is_listed(p, pred)) begin
               if (mdl_free_head == 0) rs.status = cll_pkg::ST_FULL;
               else begin
                  cur = take_slot();
                  mdl_values[cur] = mdl_values[p];
                  mdl_links[cur] = mdl_links[p];
                  mdl_values[p] = rq.value;
                  mdl_links[p] = cur;
                  rs.slot_out = p;
               end
            end else if (p == 0 || p > SLOTS || is_free(p)) begin
               rs.status = cll_pkg::ST_UNDEF;
            end else begin
               cur = mdl_list_head;
               nx = 0;
               for (int n = 0; n < SLOTS && cur != 0; n++) begin
                  nx = cur;
                  cur = link_of(cur);
               end
               mdl_values[p] = rq.value;
               mdl_links[p] = 0;
               if (nx != 0) mdl_links[nx] = p;
               rs.slot_out = p;
            end
         end
         cll_pkg::OP_DELETE: begin
            if (!is_listed(p, pred)) begin
               rs.status = cll_pkg::ST_UNDEF;
               rs.slot_out = p;
            end else begin
               rs.slot_out = mdl_links[p];
               if (p == mdl_list_head) mdl_list_head = mdl_links[p];
               else mdl_links[pred] = mdl_links[p];
               release_slot(p);
            end
         end
         cll_pkg::OP_LOCATE: begin
            cur = mdl_list_head;
            for (int n = 0; n < SLOTS && cur != 0; n++) begin
               if (mdl_values[cur] == rq.value) begin
                  rs.slot_out = cur;
                  break;
               end
               cur = link_of(cur);
            end
         end
         cll_pkg::OP_RETRIEVE: begin
            if (!is_listed(p, pred)) rs.status = cll_pkg::ST_UNDEF;
            else begin
               rs.value_out = mdl_values[p];
               rs.slot_out = p;
            end
         end
         cll_pkg::OP_NEXT: begin
            if (!is_listed(p, pred)) rs.status = cll_pkg::ST_UNDEF;
            else rs.slot_out = mdl_links[p];
         end
         cll_pkg::OP_PREVIOUS: begin
            if (!is_listed(p, pred) || p == mdl_list_head) rs.status = cll_pkg::ST_UNDEF;
            else rs.slot_out = pred;
         end
         cll_pkg::OP_CLEAR: begin
            cur = mdl_list_head;
            for (int n = 0; n < SLOTS && cur != 0; n++) begin
               nx = link_of(cur);
               release_slot(cur);
               cur = nx;
            end
            mdl_list_head = 0;
         end
         default: begin
            if (mdl_free_head == 0) rs.status = cll_pkg::ST_FULL;
            else rs.slot_out = take_slot();
         end
      endcase
      rs.head_out = mdl_list_head;
      return rs;
   endfunction

   // value drawn from a small pool so locates often hit
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 7);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom();
      endcase
   endfunction

   // queue one request for the driver
   function automatic void push_request(cll_pkg::op_type op, logic [4:0] s, logic [31:0] v);
      request_type rq;
      rq.op = op;
      rq.slot = s;
      rq.value = v;
      pending_requests.push_back(rq);
   endfunction

   // stimulus
   initial begin
      int n;
      list_reset();
      // directed opening
      push_request(cll_pkg::OP_RETRIEVE, 5'd1, 32'd0);          // empty list lookups
      push_request(cll_pkg::OP_PREVIOUS, 5'd0, 32'd0);
      push_request(cll_pkg::OP_DELETE, 5'd31, 32'd0);
      push_request(cll_pkg::OP_INSERT, 5'd0, 32'hFFFF_FFFF);    // first insert becomes head
      push_request(cll_pkg::OP_INSERT, 5'd1, 32'd0);            // insert at listed slot
      push_request(cll_pkg::OP_INSERT, 5'd0, 32'd5);            // append of null slot
      push_request(cll_pkg::OP_INSERT, 5'd30, 32'd5);           // append of a free slot
      push_request(cll_pkg::OP_ALLOCATE, 5'd0, 32'd0);
      push_request(cll_pkg::OP_INSERT, 5'd3, 32'hA5A5_5A5A);    // append of allocated slot
      push_request(cll_pkg::OP_LOCATE, 5'd0, 32'hFFFF_FFFF);
      push_request(cll_pkg::OP_LOCATE, 5'd0, 32'h1234_5678);
      push_request(cll_pkg::OP_RETRIEVE, 5'd1, 32'd0);
      push_request(cll_pkg::OP_NEXT, 5'd1, 32'd0);
      push_request(cll_pkg::OP_NEXT, 5'd3, 32'd0);
      push_request(cll_pkg::OP_PREVIOUS, 5'd1, 32'd0);          // previous of head
      push_request(cll_pkg::OP_PREVIOUS, 5'd3, 32'd0);
      push_request(cll_pkg::OP_DELETE, 5'd2, 32'd0);
      push_request(cll_pkg::OP_DELETE, 5'd1, 32'd0);            // delete of head
      push_request(cll_pkg::OP_CLEAR, 5'd0, 32'd0);
      for (int i = 0; i < 32; i++) push_request(cll_pkg::OP_ALLOCATE, 5'(i), 32'd0);
      push_request(cll_pkg::OP_INSERT, 5'd4, 32'd1);            // no free slot
      push_request(cll_pkg::OP_INSERT, 5'd4, 32'd2);            // empty list, still no free slot
      push_request(cll_pkg::OP_INSERT, 5'd4, 32'd3);            // empty list, full once more
      push_request(cll_pkg::OP_CLEAR, 5'd0, 32'd0);
      // random part: mostly list building and walking, with clears to refill
      n = 0;
      while (n < 1600) begin
         cll_pkg::op_type op;
         logic [4:0] s;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: op = cll_pkg::OP_INSERT;
            6, 7, 8: op = cll_pkg::OP_DELETE;
            9, 10: op = cll_pkg::OP_LOCATE;
            11, 12: op = cll_pkg::OP_RETRIEVE;
            13, 14: op = cll_pkg::OP_NEXT;
            15, 16: op = cll_pkg::OP_PREVIOUS;
            17: op = ($urandom_range(0, 2) == 0) ? cll_pkg::OP_CLEAR : cll_pkg::OP_ALLOCATE;
            default: op = cll_pkg::OP_ALLOCATE;
         endcase
         s = ($urandom_range(0, 9) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 12));
         push_request(op, s, pick_value());
         n++;
      end
      stimulus_done = 1;
   end

   // reset and the three idling phases
   initial begin
      reset = 1;
      repeat (11) @(posedge clock);
      reset <= 0;
      wait (stimulus_done);
      wait (pending_requests.size() < 1100);
      send_idle_pct = 84;
      recv_idle_pct = 21;
      wait (pending_requests.size() < 550);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait (pending_requests.size() == 0 && !req_tvalid && expected_responses.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_responses.size() == 0)
         $display("tb_cursor_linked_list_engine: done, clean");
      else
         $display("tb_cursor_linked_list_engine: done, errors");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      request_type rq;
      if (reset) begin
         req_tvalid <= 0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            rq = request_type'(req_tdata);
            expected_responses.push_back(list_apply(rq));
         end
         if (pending_requests.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
            req_tdata  <= pending_requests.pop_front();
            req_tvalid <= 1;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // response monitor and ready pattern
   always @(posedge clock) begin
      response_type got;
      response_type want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = response_type'(rsp_tdata[43:0]);
            if (expected_responses.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               if (got.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, got.status);
                  error_count++;
               end
               if (got.slot_out !== want.slot_out) begin
                  $error("slot_out expected %0d got %0d", want.slot_out, got.slot_out);
                  error_count++;
               end
               if (got.value_out !== want.value_out) begin
                  $error("value_out expected %h got %h", want.value_out, got.value_out);
                  error_count++;
               end
               if (got.head_out !== want.head_out) begin
                  $error("head_out expected %0d got %0d", want.head_out, got.head_out);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(1, 100) > recv_idle_pct);
      end
   end

   // watchdog on stalled handshakes
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("tb_cursor_linked_list_engine: done, errors");
         $finish;
      end
   end

endmodule
